// File: rtl/bcs_pkg.sv
package bcs_pkg;

  localparam int MAX_POINTS_DEF    = 8;
  localparam int COORD_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int PCOUNT_BITS  = 4;
  localparam int SAMPLE_BITS  = 13;
  localparam int PIDX_BITS    = 3;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 13;

  localparam logic [PCOUNT_BITS-1:0] PCOUNT_RST = PCOUNT_BITS'(5);
  localparam logic [SAMPLE_BITS-1:0] SCOUNT_RST = SAMPLE_BITS'(2048);
  localparam logic [SAMPLE_BITS-1:0] MAX_SAMPLES = SAMPLE_BITS'(4096);

  localparam logic [CFG_IDX_BITS-1:0] REG_POINT_COUNT  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_COUNT = CFG_IDX_BITS'(1);

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // binomials for up to 16 points, C(15,7) needs 13 bits
  localparam int BINOM_ROWS     = 16;
  localparam int BINOM_IDX_BITS = 4;
  localparam int BINOM_BITS     = 13;

  typedef logic [BINOM_ROWS-1:0][BINOM_ROWS-1:0][BINOM_BITS-1:0] binom_tab_t;

  function automatic binom_tab_t binom_build();
    binom_tab_t tab;
    tab = '0;
    for (int r = 0; r < BINOM_ROWS; r++) begin
      tab[r][0] = BINOM_BITS'(1);
      for (int c = 1; c <= r; c++) begin
        tab[r][c] = tab[r-1][c-1] + tab[r-1][c];
      end
    end
    return tab;
  endfunction

  localparam binom_tab_t BINOM = binom_build();

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PREP,
    ST_UPOW,
    ST_TERM,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    TS_BASIS,
    TS_PX,
    TS_PY,
    TS_XLO,
    TS_XHI,
    TS_YLO,
    TS_YHI,
    TS_TPOW
  } term_step_e;

endpackage

// File: rtl/bezier_curve_sampler.sv
// channel   direction  handshake                    payload
// input     in         in_valid_i / in_stall_o      operation, point_index, point_x/y, sample_index
// output    out        out_valid_o / out_stall_i    curve_x, curve_y, last_sample
// config    in         cfg_we_i (no wait)           cfg_idx_i, cfg_data_i
//
// a load item leaves in_stall_o low
// a sample item holds in_stall_o high until its result moves to the output register, paced
// by the one-bit-per-cycle divider for t and the single shared multiplier
// rst_ni clears control and loads point_count 5, sample_count 2048; control points need a load
// a finished result waits in the output register; loads are still taken meanwhile
module bezier_curve_sampler #(
  parameter int MAX_POINTS    = bcs_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS    = bcs_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = bcs_pkg::FRACTION_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  operation_i,
  input  logic [bcs_pkg::PIDX_BITS-1:0]         point_index_i,
  input  logic signed [COORD_BITS-1:0]          point_x_i,
  input  logic signed [COORD_BITS-1:0]          point_y_i,
  input  logic [bcs_pkg::SAMPLE_BITS-1:0]       sample_index_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [COORD_BITS-1:0]          curve_x_o,
  output logic signed [COORD_BITS-1:0]          curve_y_o,
  output logic                                  last_sample_o,
  input  logic                                  cfg_we_i,
  input  logic [bcs_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [bcs_pkg::CFG_DATA_BITS-1:0]     cfg_data_i
);

  localparam int FB   = FRACTION_BITS;
  localparam int IW   = $clog2(MAX_POINTS);
  localparam int SB   = bcs_pkg::SAMPLE_BITS;
  localparam int PW   = COORD_BITS + FB + 1;
  localparam int LO   = PW / 2;
  localparam int AW1  = (FB + 2 > COORD_BITS) ? FB + 2 : COORD_BITS;
  localparam int AW   = (AW1 > LO + 1) ? AW1 : LO + 1;
  localparam int BW   = (FB + 2 > bcs_pkg::BINOM_BITS + 1) ? FB + 2 : bcs_pkg::BINOM_BITS + 1;
  localparam int PRW  = AW + BW;
  localparam int AC1  = PW + bcs_pkg::BINOM_BITS + 5;
  localparam int AC2  = PRW + LO;
  localparam int ACCW = (AC1 > AC2) ? AC1 : AC2;
  localparam int NUMW = SB + FB + 1;
  localparam int DCW  = $clog2(FB + 1);
  localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

  bcs_pkg::state_e     state_q, state_d;
  bcs_pkg::term_step_e step_q, step_d;

  logic [IW-1:0]  idx_q;
  logic [DCW-1:0] div_cnt_q;
  logic           out_valid_q;
  logic [bcs_pkg::PCOUNT_BITS-1:0] pc_q;
  logic [SB-1:0]  sc_q;

  logic signed [COORD_BITS-1:0] cp_x_q [MAX_POINTS];
  logic signed [COORD_BITS-1:0] cp_y_q [MAX_POINTS];
  logic [FB:0]    upow_q [MAX_POINTS];

  logic [SB-1:0]  m_q;
  logic           last_q;
  logic [SB-1:0]  div_rem_q;
  logic [FB:0]    div_num_q;
  logic [FB:0]    div_quo_q;
  logic [FB:0]    u_q, pw_q, tp_q, b_q;
  logic [PW-1:0]  px_q, py_q;
  logic signed [ACCW-1:0] acc_x_q, acc_y_q;
  logic signed [COORD_BITS-1:0] curve_x_q, curve_y_q;
  logic           out_last_q;

  logic           in_acc, out_fire;
  logic [IW-1:0]  n_act;
  logic [SB-1:0]  m_cl, k_cl;
  logic [NUMW-1:0] num;
  logic [SB:0]    div_trial;
  logic           div_ge;
  logic [SB-1:0]  div_rem_nx;
  logic signed [COORD_BITS-1:0] cp_x_rd, cp_y_rd;
  logic [FB:0]    upow_rd;
  logic [bcs_pkg::BINOM_BITS-1:0] binom_c;
  logic signed [AW-1:0]  mul_a;
  logic signed [BW-1:0]  mul_b;
  logic signed [PRW-1:0] mul_p;
  logic [PRW-1:0] qsum;
  logic [FB:0]    qm;
  logic signed [ACCW-1:0] rx, ry, qx, qy;

  function automatic logic [COORD_BITS-1:0] sat(input logic signed [ACCW-1:0] q);
    logic fits;
    fits = (&q[ACCW-1:COORD_BITS-1]) || !(|q[ACCW-1:COORD_BITS-1]);
    if (fits) begin
      return q[COORD_BITS-1:0];
    end else if (q[ACCW-1]) begin
      return {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_BITS-1){1'b1}}};
    end
  endfunction

  // clamped configuration
  always_comb begin
    if (pc_q < bcs_pkg::PCOUNT_BITS'(2)) begin
      n_act = IW'(1);
    end else if ({1'b0, pc_q} > (bcs_pkg::PCOUNT_BITS + 1)'(MAX_POINTS)) begin
      n_act = IW'(MAX_POINTS - 1);
    end else begin
      n_act = IW'(pc_q - bcs_pkg::PCOUNT_BITS'(1));
    end
    if (sc_q == '0) begin
      m_cl = SB'(1);
    end else if (sc_q > bcs_pkg::MAX_SAMPLES) begin
      m_cl = bcs_pkg::MAX_SAMPLES;
    end else begin
      m_cl = sc_q;
    end
    k_cl = (sample_index_i > m_cl) ? m_cl : sample_index_i;
    num  = {1'b0, k_cl, {FB{1'b0}}} + NUMW'(m_cl >> 1);
  end

  // restoring divider step
  assign div_trial  = {div_rem_q, div_num_q[FB]};
  assign div_ge     = div_trial >= {1'b0, m_q};
  assign div_rem_nx = div_ge ? SB'(div_trial - {1'b0, m_q}) : SB'(div_trial);

  assign cp_x_rd = cp_x_q[idx_q];
  assign cp_y_rd = cp_y_q[idx_q];
  assign upow_rd = upow_q[IW'(n_act - idx_q)];
  assign binom_c = bcs_pkg::BINOM[bcs_pkg::BINOM_IDX_BITS'(n_act)]
                                 [bcs_pkg::BINOM_IDX_BITS'(idx_q)];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      bcs_pkg::ST_UPOW: begin
        mul_a = AW'(pw_q);
        mul_b = BW'(u_q);
      end
      bcs_pkg::ST_TERM: begin
        case (step_q)
          bcs_pkg::TS_BASIS: begin
            mul_a = AW'(tp_q);
            mul_b = BW'(upow_rd);
          end
          bcs_pkg::TS_PX: begin
            mul_a = AW'(cp_x_rd);
            mul_b = BW'(b_q);
          end
          bcs_pkg::TS_PY: begin
            mul_a = AW'(cp_y_rd);
            mul_b = BW'(b_q);
          end
          bcs_pkg::TS_XLO: begin
            mul_a = AW'(px_q[LO-1:0]);
            mul_b = BW'(binom_c);
          end
          bcs_pkg::TS_XHI: begin
            mul_a = AW'(signed'(px_q[PW-1:LO]));
            mul_b = BW'(binom_c);
          end
          bcs_pkg::TS_YLO: begin
            mul_a = AW'(py_q[LO-1:0]);
            mul_b = BW'(binom_c);
          end
          bcs_pkg::TS_YHI: begin
            mul_a = AW'(signed'(py_q[PW-1:LO]));
            mul_b = BW'(binom_c);
          end
          bcs_pkg::TS_TPOW: begin
            mul_a = AW'(tp_q);
            mul_b = BW'(div_quo_q);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign qsum  = PRW'(mul_p) + (PRW'(1) << (FB - 1));
  assign qm    = qsum[FB +: FB + 1];

  assign rx = acc_x_q + (ACCW'(1) <<< (FB - 1));
  assign ry = acc_y_q + (ACCW'(1) <<< (FB - 1));
  assign qx = rx >>> FB;
  assign qy = ry >>> FB;

  // outputs
  always_comb begin
    in_stall_o    = (state_q != bcs_pkg::ST_IDLE);
    in_acc        = in_valid_i && !in_stall_o;
    out_fire      = (state_q == bcs_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);
    out_valid_o   = out_valid_q;
    curve_x_o     = curve_x_q;
    curve_y_o     = curve_y_q;
    last_sample_o = out_last_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      bcs_pkg::ST_IDLE: begin
        if (in_acc && operation_i == bcs_pkg::OP_SAMPLE) begin
          state_d = bcs_pkg::ST_DIV;
        end
      end
      bcs_pkg::ST_DIV: begin
        if (div_cnt_q == DCW'(FB)) begin
          state_d = bcs_pkg::ST_PREP;
        end
      end
      bcs_pkg::ST_PREP: begin
        state_d = bcs_pkg::ST_UPOW;
      end
      bcs_pkg::ST_UPOW: begin
        if (idx_q == n_act) begin
          state_d = bcs_pkg::ST_TERM;
          step_d  = bcs_pkg::TS_BASIS;
        end
      end
      bcs_pkg::ST_TERM: begin
        case (step_q)
          bcs_pkg::TS_BASIS: step_d = bcs_pkg::TS_PX;
          bcs_pkg::TS_PX:    step_d = bcs_pkg::TS_PY;
          bcs_pkg::TS_PY:    step_d = bcs_pkg::TS_XLO;
          bcs_pkg::TS_XLO:   step_d = bcs_pkg::TS_XHI;
          bcs_pkg::TS_XHI:   step_d = bcs_pkg::TS_YLO;
          bcs_pkg::TS_YLO:   step_d = bcs_pkg::TS_YHI;
          bcs_pkg::TS_YHI: begin
            if (idx_q == n_act) begin
              state_d = bcs_pkg::ST_DONE;
            end else begin
              step_d = bcs_pkg::TS_TPOW;
            end
          end
          bcs_pkg::TS_TPOW:  step_d = bcs_pkg::TS_BASIS;
          default:           step_d = bcs_pkg::TS_BASIS;
        endcase
      end
      bcs_pkg::ST_DONE: begin
        if (out_fire) begin
          state_d = bcs_pkg::ST_IDLE;
        end
      end
      default: state_d = bcs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bcs_pkg::ST_IDLE;
      step_q      <= bcs_pkg::TS_BASIS;
      idx_q       <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      pc_q        <= bcs_pkg::PCOUNT_RST;
      sc_q        <= bcs_pkg::SCOUNT_RST;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_fire || (out_valid_q && out_stall_i);
      if (in_acc) begin
        div_cnt_q <= '0;
      end else if (state_q == bcs_pkg::ST_DIV) begin
        div_cnt_q <= div_cnt_q + DCW'(1);
      end
      case (state_q)
        bcs_pkg::ST_PREP: idx_q <= IW'(1);
        bcs_pkg::ST_UPOW: idx_q <= (idx_q == n_act) ? '0 : idx_q + IW'(1);
        bcs_pkg::ST_TERM: begin
          if (step_q == bcs_pkg::TS_TPOW) begin
            idx_q <= idx_q + IW'(1);
          end
        end
        default: idx_q <= idx_q;
      endcase
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bcs_pkg::REG_POINT_COUNT:  pc_q <= bcs_pkg::PCOUNT_BITS'(cfg_data_i);
          bcs_pkg::REG_SAMPLE_COUNT: sc_q <= SB'(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && operation_i == bcs_pkg::OP_LOAD && int'(point_index_i) < MAX_POINTS) begin
      cp_x_q[IW'(point_index_i)] <= point_x_i;
      cp_y_q[IW'(point_index_i)] <= point_y_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bcs_pkg::ST_PREP) begin
      upow_q[IW'(0)] <= ONE;
    end else if (state_q == bcs_pkg::ST_UPOW) begin
      upow_q[idx_q] <= qm;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && operation_i == bcs_pkg::OP_SAMPLE) begin
      m_q       <= m_cl;
      last_q    <= (sample_index_i >= m_cl);
      div_rem_q <= num[NUMW-1:FB+1];
      div_num_q <= num[FB:0];
      div_quo_q <= '0;
    end
    case (state_q)
      bcs_pkg::ST_DIV: begin
        div_rem_q <= div_rem_nx;
        div_num_q <= {div_num_q[FB-1:0], 1'b0};
        div_quo_q <= {div_quo_q[FB-1:0], div_ge};
      end
      bcs_pkg::ST_PREP: begin
        u_q     <= ONE - div_quo_q;
        pw_q    <= ONE;
        tp_q    <= ONE;
        acc_x_q <= '0;
        acc_y_q <= '0;
      end
      bcs_pkg::ST_UPOW: pw_q <= qm;
      bcs_pkg::ST_TERM: begin
        case (step_q)
          bcs_pkg::TS_BASIS: b_q     <= qm;
          bcs_pkg::TS_PX:    px_q    <= mul_p[PW-1:0];
          bcs_pkg::TS_PY:    py_q    <= mul_p[PW-1:0];
          bcs_pkg::TS_XLO:   acc_x_q <= acc_x_q + ACCW'(mul_p);
          bcs_pkg::TS_XHI:   acc_x_q <= acc_x_q + (ACCW'(mul_p) <<< LO);
          bcs_pkg::TS_YLO:   acc_y_q <= acc_y_q + ACCW'(mul_p);
          bcs_pkg::TS_YHI:   acc_y_q <= acc_y_q + (ACCW'(mul_p) <<< LO);
          bcs_pkg::TS_TPOW:  tp_q    <= qm;
          default: ;
        endcase
      end
      bcs_pkg::ST_DONE: begin
        if (out_fire) begin
          curve_x_q  <= sat(qx);
          curve_y_q  <= sat(qy);
          out_last_q <= last_q;
        end
      end
      default: ;
    endcase
  end

  a_load_keeps_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && operation_i == bcs_pkg::OP_LOAD |=> !in_stall_o)
    else $error("load item stalled the input");

  a_sample_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && operation_i == bcs_pkg::OP_SAMPLE |=>
      state_q == bcs_pkg::ST_DIV && div_cnt_q == '0)
    else $error("sample item did not start the divider");

  a_div_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bcs_pkg::ST_DIV |-> div_rem_q < m_q)
    else $error("divider remainder not below divisor");

  a_t_plus_u: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bcs_pkg::ST_UPOW || state_q == bcs_pkg::ST_TERM |->
      (FB + 2)'(div_quo_q) + (FB + 2)'(u_q) == (FB + 2)'(ONE))
    else $error("t and 1 - t out of step");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |=> out_valid_o && state_q == bcs_pkg::ST_IDLE)
    else $error("finished sample did not reach the output register");

endmodule

// File: bench/tb_bezier_curve_sampler.sv
module tb_bezier_curve_sampler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_POINTS = bcs_pkg::MAX_POINTS_DEF;
  localparam int CW = bcs_pkg::COORD_BITS_DEF;
  localparam int FB = bcs_pkg::FRACTION_BITS_DEF;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 56;
  localparam int SETTLE_CYCLES = 150;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic                            op;
    logic [bcs_pkg::PIDX_BITS-1:0]   slot;
    logic signed [CW-1:0]            px;
    logic signed [CW-1:0]            py;
    logic [bcs_pkg::SAMPLE_BITS-1:0] k;
  } curve_item_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
  } curve_point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic operation_i = bcs_pkg::OP_LOAD;
  logic [bcs_pkg::PIDX_BITS-1:0] point_index_i = '0;
  logic signed [CW-1:0] point_x_i = '0;
  logic signed [CW-1:0] point_y_i = '0;
  logic [bcs_pkg::SAMPLE_BITS-1:0] sample_index_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [CW-1:0] curve_x_o;
  logic signed [CW-1:0] curve_y_o;
  logic last_sample_o;
  logic cfg_we_i = 1'b0;
  logic [bcs_pkg::CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [bcs_pkg::CFG_DATA_BITS-1:0] cfg_data_i = '0;

  curve_item_t pending_items[$];
  curve_point_t expected_points[$];
  curve_item_t cur_item;
  logic signed [CW-1:0] ctrl_x[NUM_POINTS];
  logic signed [CW-1:0] ctrl_y[NUM_POINTS];
  logic [bcs_pkg::PCOUNT_BITS-1:0] cfg_points = bcs_pkg::PCOUNT_RST;
  logic [bcs_pkg::SAMPLE_BITS-1:0] cfg_samples = bcs_pkg::SCOUNT_RST;
  bit quiet_run = 1'b0;
  int fail_count = 0;
  int cycle_count = 0;

  bezier_curve_sampler DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .point_index_i  (point_index_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .sample_index_i (sample_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .curve_x_o      (curve_x_o),
    .curve_y_o      (curve_y_o),
    .last_sample_o  (last_sample_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic longint unsigned samples_in_use();
    if (cfg_samples == 0) return 64'd1;
    if (cfg_samples > bcs_pkg::MAX_SAMPLES) return 64'(bcs_pkg::MAX_SAMPLES);
    return 64'(cfg_samples);
  endfunction

  function automatic int points_in_use();
    if (cfg_points < 2) return 2;
    if (cfg_points > NUM_POINTS) return NUM_POINTS;
    return int'(cfg_points);
  endfunction

  function automatic longint unsigned fix_mul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << (FB - 1))) >> FB;
  endfunction

  function automatic logic signed [CW-1:0] round_coord(longint acc);
    longint q;
    q = (acc + (64'sd1 << (FB - 1))) >>> FB;
    if (q > (64'sd1 << (CW - 1)) - 1) q = (64'sd1 << (CW - 1)) - 1;
    if (q < -(64'sd1 << (CW - 1))) q = -(64'sd1 << (CW - 1));
    return q[CW-1:0];
  endfunction

  // bernstein sum at t = k / sample count, q1.16 blends
  function automatic curve_point_t eval_curve(logic [bcs_pkg::SAMPLE_BITS-1:0] k_in);
    longint unsigned m, k, t, u;
    longint unsigned tpow[NUM_POINTS];
    longint unsigned upow[NUM_POINTS];
    longint unsigned binom[NUM_POINTS];
    longint basis, sx, sy;
    int np, n;
    curve_point_t res;
    m = samples_in_use();
    k = 64'(k_in);
    if (k > m) k = m;
    t = ((k << FB) + m / 2) / m;
    u = (64'd1 << FB) - t;
    np = points_in_use();
    n = np - 1;
    binom[n] = 64'd1;
    for (int i = n - 1; i >= 0; i--) binom[i] = binom[i + 1] * 64'(i + 1) / 64'(n - i);
    tpow[0] = 64'd1 << FB;
    upow[0] = 64'd1 << FB;
    for (int i = 1; i < np; i++) begin
      tpow[i] = fix_mul(tpow[i - 1], t);
      upow[i] = fix_mul(upow[i - 1], u);
    end
    sx = 0;
    sy = 0;
    for (int i = 0; i < np; i++) begin
      basis = longint'(binom[i] * fix_mul(tpow[i], upow[n - i]));
      sx += longint'(ctrl_x[i]) * basis;
      sy += longint'(ctrl_y[i]) * basis;
    end
    res.x = round_coord(sx);
    res.y = round_coord(sy);
    res.last = (k == m);
    return res;
  endfunction

  function automatic int rand_coord();
    int r;
    r = int'($urandom_range(99));
    if (r < 10) return -(1 << (CW - 1));
    if (r < 20) return (1 << (CW - 1)) - 1;
    return int'($urandom_range((1 << CW) - 1)) - (1 << (CW - 1));
  endfunction

  task automatic queue_load(int slot, int x, int y);
    curve_item_t it;
    it.op = bcs_pkg::OP_LOAD;
    it.slot = bcs_pkg::PIDX_BITS'(slot);
    it.px = CW'(x);
    it.py = CW'(y);
    it.k = bcs_pkg::SAMPLE_BITS'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic queue_sample(int k);
    curve_item_t it;
    it.op = bcs_pkg::OP_SAMPLE;
    it.slot = bcs_pkg::PIDX_BITS'($urandom);
    it.px = CW'($urandom);
    it.py = CW'($urandom);
    it.k = bcs_pkg::SAMPLE_BITS'(k);
    pending_items.push_back(it);
  endtask

  task automatic wait_quiet();
    while (pending_items.size() != 0 || in_valid_i || expected_points.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [bcs_pkg::CFG_IDX_BITS-1:0] idx, int val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= bcs_pkg::CFG_DATA_BITS'(val);
    if (idx == bcs_pkg::REG_POINT_COUNT) cfg_points = bcs_pkg::PCOUNT_BITS'(val);
    else cfg_samples = bcs_pkg::SAMPLE_BITS'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // item driver and predictor update on acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (cur_item.op == bcs_pkg::OP_LOAD) begin
          ctrl_x[cur_item.slot] = cur_item.px;
          ctrl_y[cur_item.slot] = cur_item.py;
        end else begin
          expected_points.push_back(eval_curve(cur_item.k));
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 && (quiet_run || $urandom_range(99) >= 29)) begin
          cur_item = pending_items.pop_front();
          in_valid_i <= 1'b1;
          operation_i <= cur_item.op;
          point_index_i <= cur_item.slot;
          point_x_i <= cur_item.px;
          point_y_i <= cur_item.py;
          sample_index_i <= cur_item.k;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    curve_point_t exp_pt;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          $error("unexpected item x=%0d y=%0d last=%0d", curve_x_o, curve_y_o, last_sample_o);
          fail_count++;
        end else begin
          exp_pt = expected_points.pop_front();
          if (curve_x_o !== exp_pt.x) begin
            $error("curve_x expected %0d got %0d", exp_pt.x, curve_x_o);
            fail_count++;
          end
          if (curve_y_o !== exp_pt.y) begin
            $error("curve_y expected %0d got %0d", exp_pt.y, curve_y_o);
            fail_count++;
          end
          if (last_sample_o !== exp_pt.last) begin
            $error("last_sample expected %0d got %0d", exp_pt.last, last_sample_o);
            fail_count++;
          end
        end
      end
      out_stall_i <= !quiet_run && ($urandom_range(99) < 29);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned phase_points[NUM_PHASES];
    int unsigned phase_samples[NUM_PHASES];
    int m;
    int r;
    int k;
    phase_points = '{2, 8, 0, 15, 3, 4, 7, 6, 1, 5};
    phase_samples = '{1, 4096, 0, 8191, 7, 100, 4095, 3, 4097, 2048};
    for (int i = 0; i < NUM_POINTS; i++) begin
      ctrl_x[i] = '0;
      ctrl_y[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every slot written before any sample
    queue_load(0, -32768, 32767);
    queue_load(1, 32767, -32768);
    queue_load(2, 0, 0);
    queue_load(3, -1, -1);
    queue_load(4, 1, -2);
    for (int i = 5; i < NUM_POINTS; i++) queue_load(i, rand_coord(), rand_coord());
    queue_sample(0);
    queue_sample(1);
    queue_sample(1024);
    queue_sample(2047);
    queue_sample(2048);
    queue_sample(2049);
    queue_sample(8191);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_quiet();
      write_reg(bcs_pkg::REG_POINT_COUNT, int'(phase_points[p]));
      write_reg(bcs_pkg::REG_SAMPLE_COUNT, int'(phase_samples[p]));
      quiet_run = (p == 4);
      m = int'(samples_in_use());
      for (int i = 0; i < NUM_POINTS; i++) begin
        if (p % 4 == 0) queue_load(i, 32767, -32768);
        else if (p % 4 == 2) queue_load(i, -32768, 32767);
        else queue_load(i, rand_coord(), rand_coord());
      end
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        r = int'($urandom_range(99));
        if (r < 30) begin
          queue_load(int'($urandom_range(NUM_POINTS - 1)), rand_coord(), rand_coord());
        end else begin
          r = int'($urandom_range(99));
          if (r < 15) k = int'($urandom_range((1 << bcs_pkg::SAMPLE_BITS) - 1));
          else if (r < 25) k = m;
          else if (r < 30) k = 0;
          else k = int'($urandom_range(m));
          queue_sample(k);
        end
      end
    end

    while (pending_items.size() != 0 || in_valid_i || expected_points.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_points.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
